@@ src/qpe_pkg.sv @@
// Shared types, constants and helper functions of the quoted-printable encoder.
package qpe_pkg;

    localparam int unsigned LIMIT_W      = 7;
    localparam int unsigned COUNT_W      = 7;
    localparam int unsigned STEP_W       = 3;
    localparam int unsigned QUEUE_DEPTH  = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd75;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 7'd125;

    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_EQ  = 8'd61;

    // One classified byte waiting to be expanded into characters.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       literal;
        logic       soft_break;
    } job_t;

    function automatic logic is_literal(input logic [7:0] b);
        return (b == CHAR_TAB) || ((b >= 8'd32) && (b <= 8'd60))
            || ((b >= 8'd62) && (b <= 8'd126));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = 8'd48 + {4'd0, nib};
        end
        else
        begin
            r = 8'd55 + {4'd0, nib};
        end
        return r;
    endfunction

endpackage

@@ src/qpe_if.sv @@
// Valid/ready channel interfaces for message bytes and encoded characters.
interface qpe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       message_start;

    modport source (output valid, output data_byte, output message_start, input ready);
    modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface qpe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ src/qpe_front.sv @@
// Front end: accepts bytes, classifies them and tracks the line count.
module qpe_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [qpe_pkg::LIMIT_W-1:0]      line_limit,
    qpe_byte_if.sink                         msg,
    input  logic                             queue_full,
    output logic                             push,
    output qpe_pkg::job_t                    job
);

    logic [qpe_pkg::COUNT_W-1:0] line_count_reg;
    logic [qpe_pkg::COUNT_W-1:0] line_count_next;
    logic [qpe_pkg::LIMIT_W-1:0] limit_eff;
    logic [qpe_pkg::COUNT_W-1:0] base;
    logic [qpe_pkg::COUNT_W:0]   sum;
    logic                        lit;
    logic                        brk;

    assign msg.ready = !queue_full;
    assign push      = msg.valid && !queue_full;

    always_comb
    begin
        limit_eff = (line_limit > qpe_pkg::LIMIT_MAX) ? qpe_pkg::LIMIT_MAX : line_limit;
        lit       = qpe_pkg::is_literal(msg.data_byte);
        base      = msg.message_start ? '0 : line_count_reg;
        sum       = {1'b0, base} + (lit ? 8'd1 : 8'd3);
        brk       = (sum >= {1'b0, limit_eff});
        line_count_next = line_count_reg;
        if (push)
        begin
            line_count_next = brk ? '0 : sum[qpe_pkg::COUNT_W-1:0];
        end
        job.data_byte  = msg.data_byte;
        job.literal    = lit;
        job.soft_break = brk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
        end
        else
        begin
            line_count_reg <= line_count_next;
        end
    end

endmodule

@@ src/qpe_queue.sv @@
// Small job queue between front end and character sequencer.
module qpe_queue #(
    parameter int unsigned DEPTH = qpe_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qpe_pkg::job_t push_job,
    input  logic          pop,
    output qpe_pkg::job_t head_job,
    output logic          not_empty,
    output logic          full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    qpe_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_job  = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/qpe_back.sv @@
// Back end: expands one job into characters, one per cycle while the receiver is ready, into an output register.
module qpe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  qpe_pkg::job_t head_job,
    input  logic          not_empty,
    output logic          pop,
    qpe_char_if.source    enc
);

    qpe_pkg::job_t              cur_job_reg;
    logic                       cur_valid_reg;
    logic [qpe_pkg::STEP_W-1:0] step_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_char_reg;
    logic                       out_last_reg;

    logic [qpe_pkg::STEP_W-1:0] brk_pos;
    logic [qpe_pkg::STEP_W-1:0] last_step;
    logic [7:0]                 ch;
    logic                       is_last;
    logic                       out_load;

    assign enc.valid       = out_valid_reg;
    assign enc.out_char    = out_char_reg;
    assign enc.last_of_run = out_last_reg;

    always_comb
    begin
        brk_pos   = step_reg - (cur_job_reg.literal ? 3'd1 : 3'd3);
        last_step = (cur_job_reg.literal ? 3'd0 : 3'd2)
                  + (cur_job_reg.soft_break ? 3'd3 : 3'd0);
        is_last   = (step_reg == last_step);
        priority if (cur_job_reg.literal && step_reg == 3'd0)
        begin
            ch = cur_job_reg.data_byte;
        end
        else if (!cur_job_reg.literal && step_reg == 3'd0)
        begin
            ch = qpe_pkg::CHAR_EQ;
        end
        else if (!cur_job_reg.literal && step_reg == 3'd1)
        begin
            ch = qpe_pkg::hex_char(cur_job_reg.data_byte[7:4]);
        end
        else if (!cur_job_reg.literal && step_reg == 3'd2)
        begin
            ch = qpe_pkg::hex_char(cur_job_reg.data_byte[3:0]);
        end
        else
        begin
            unique case (brk_pos)
                3'd0:    ch = qpe_pkg::CHAR_EQ;
                3'd1:    ch = qpe_pkg::CHAR_CR;
                default: ch = qpe_pkg::CHAR_LF;
            endcase
        end
        out_load = cur_valid_reg && (!out_valid_reg || enc.ready);
        pop      = not_empty && (!cur_valid_reg || (out_load && is_last));
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_job_reg <= head_job;
        end
        if (out_load)
        begin
            out_char_reg <= ch;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= '0;
            end
            else if (out_load)
            begin
                if (is_last)
                begin
                    cur_valid_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (enc.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ src/quoted_printable_encoder.sv @@
// Top level of the quoted-printable encoder.
//
// Channels: msg takes one message byte per item (data_byte, message_start);
// enc gives one encoded character per item (out_char, last_of_run), and
// last_of_run marks the final character that belongs to one input byte.
// cfg_we/cfg_wdata write line_limit (reset 75); write only while idle.
//
// A literal byte yields one character, an escaped byte three ("=XY"), and a
// soft break "=" CR LF adds three more, so an item yields 1 to 6 characters;
// the one-character-per-cycle output register sets the rate while the receiver
// is ready. A byte goes through the job queue and the current-job register into
// the output register. Input items are taken every cycle while the job queue
// has room, so bytes keep flowing in while earlier ones are still being expanded.
//
// Reset clears the line count, the queue and the output register, and loads
// the limit with 75. If the receiver stalls, the output register holds its
// character, the sequencer waits, and the front stalls once the queue fills.
module quoted_printable_encoder #(
    parameter int unsigned QUEUE_DEPTH = qpe_pkg::QUEUE_DEPTH  // 2 or more
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [qpe_pkg::LIMIT_W-1:0] cfg_wdata,
    qpe_byte_if.sink                    msg,
    qpe_char_if.source                  enc
);

    logic [qpe_pkg::LIMIT_W-1:0] line_limit_reg;

    // Front-to-queue and queue-to-back hookup
    logic          push;
    qpe_pkg::job_t push_job;
    logic          pop;
    qpe_pkg::job_t head_job;
    logic          not_empty;
    logic          full;

    // Limit register; clamping to the legal range happens in the front end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= qpe_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            line_limit_reg <= cfg_wdata;
        end
    end

    // Classify each byte and decide whether a soft break follows it
    qpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_limit (line_limit_reg),
        .msg        (msg),
        .queue_full (full),
        .push       (push),
        .job        (push_job)
    );

    // Decouples byte intake from character output
    qpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty),
        .full      (full)
    );

    // Character sequencer with registered output
    qpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .not_empty (not_empty),
        .pop       (pop),
        .enc       (enc)
    );

endmodule

@@ src/qpe_checker.sv @@
// Port-level assertions for the quoted-printable encoder, bound to the top level.
module qpe_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);

    logic       in_fire;
    logic       out_fire;
    logic [7:0] pending_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Bytes accepted whose final character has not yet gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'd0, in_fire} - {7'd0, out_fire && out_last};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
        else $error("stalled output character changed");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("output character with no input byte outstanding");

    a_cr_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_char == qpe_pkg::CHAR_CR |-> !out_last)
        else $error("CR ended a run");

    a_lf_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_char == qpe_pkg::CHAR_LF |-> out_last)
        else $error("LF did not end a run");

endmodule

bind quoted_printable_encoder qpe_port_checker u_qpe_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (msg.valid),
    .in_ready  (msg.ready),
    .out_valid (enc.valid),
    .out_ready (enc.ready),
    .out_char  (enc.out_char),
    .out_last  (enc.last_of_run)
);
